FILE: design/thcc_pkg.sv
`timescale 1ns / 1ps
// thcc_pkg: shared types, constants and digit helpers for the twelve-hour clock counter.
// No dependencies.
package thcc_pkg;

   localparam int unsigned HOURS_PER_TURN  = 12;
   localparam int unsigned MINUTES_PER_HR  = 60;
   localparam int unsigned SECONDS_PER_MIN = 60;
   localparam int unsigned HOUR_SECONDS    = 3600;
   localparam int unsigned MINUTE_SECONDS  = 60;
   localparam int unsigned TURN_SECONDS    = 43200;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned FIELD_W = 6;
   localparam int unsigned HOUR_W  = 4;
   localparam int unsigned COUNT_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_TICK_UP   = 3'd0,
      OP_TICK_DOWN = 3'd1,
      OP_ADD_MIN   = 3'd2,
      OP_ADD_HOUR  = 3'd3,
      OP_LOAD      = 3'd4,
      OP_HOLD      = 3'd5
   } op_type;

   // Time held in split form; hour runs 0..11, zero shows as twelve.
   typedef struct packed {
      logic [HOUR_W-1:0]  hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
   } hms_type;

   // Tens digit of a value 0..59: (n * 13) >> 7 is exact over that range.
   function automatic logic [2:0] tens_digit(input logic [FIELD_W-1:0] n);
      logic [9:0] prod;
      prod = 10'(n) * 10'd13;
      return prod[9:7];
   endfunction

   function automatic logic [3:0] ones_digit(input logic [FIELD_W-1:0] n);
      logic [FIELD_W-1:0] diff;
      diff = n - FIELD_W'(tens_digit(n)) * FIELD_W'(10);
      return diff[3:0];
   endfunction

endpackage

FILE: design/twelve_hour_clock_counter.sv
`timescale 1ns / 1ps
// twelve_hour_clock_counter: 12-hour seconds counter with decimal h:m:s readout.
// Depends on thcc_pkg.
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+------------------------------
//  req     | req_valid, req_stall, req_op, req_load_* | operation item in
//  rsp     | rsp_valid, rsp_stall, rsp_* digits/count | time after the operation out
//
// One item per cycle sustained while rsp is not stalled. An accepted item lands in the
// input register, then the state update and digit split fill the result register,
// which drives rsp_valid. Reset (synchronous) clears the time to 12:00:00 and empties
// both registers. A stall on rsp holds the result register; once the input register
// also holds an item, req_stall follows rsp_stall combinationally.
module twelve_hour_clock_counter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [thcc_pkg::OP_W-1:0]      req_op,
   input  logic [thcc_pkg::FIELD_W-1:0]   req_load_hour,
   input  logic [thcc_pkg::FIELD_W-1:0]   req_load_minute,
   input  logic [thcc_pkg::FIELD_W-1:0]   req_load_second,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hour_tens,
   output logic [3:0]                     rsp_hour_ones,
   output logic [2:0]                     rsp_minute_tens,
   output logic [3:0]                     rsp_minute_ones,
   output logic [2:0]                     rsp_second_tens,
   output logic [3:0]                     rsp_second_ones,
   output logic [thcc_pkg::COUNT_W-1:0]   rsp_elapsed_count
);
   import thcc_pkg::*;

   // Input register
   logic               in_valid_ff, in_valid_in;
   logic [OP_W-1:0]    op_ff;
   logic [FIELD_W-1:0] lh_ff, lm_ff, ls_ff;

   // Time state, kept as hour/minute/second so no division is needed on readout
   hms_type hms_ff, hms_in;

   // Result register
   logic               out_valid_ff, out_valid_in;
   logic               hour_tens_ff, hour_tens_in;
   logic [3:0]         hour_ones_ff, hour_ones_in;
   logic [2:0]         min_tens_ff, min_tens_in;
   logic [3:0]         min_ones_ff, min_ones_in;
   logic [2:0]         sec_tens_ff, sec_tens_in;
   logic [3:0]         sec_ones_ff, sec_ones_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic req_take;   // item accepted on req
   logic out_free;   // result register can take a new item this cycle
   logic advance;    // input register item moves through the update logic

   localparam logic [HOUR_W-1:0]  LAST_HOUR = HOUR_W'(HOURS_PER_TURN - 1);
   localparam logic [FIELD_W-1:0] LAST_MIN  = FIELD_W'(MINUTES_PER_HR - 1);
   localparam logic [FIELD_W-1:0] LAST_SEC  = FIELD_W'(SECONDS_PER_MIN - 1);

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   // Next time for the held item
   always_comb begin
      hms_in = hms_ff;
      case (op_ff)
         OP_TICK_UP: begin
            if (hms_ff.second == LAST_SEC) begin
               hms_in.second = '0;
               if (hms_ff.minute == LAST_MIN) begin
                  hms_in.minute = '0;
                  hms_in.hour   = (hms_ff.hour == LAST_HOUR) ? '0 : hms_ff.hour + 1'b1;
               end else begin
                  hms_in.minute = hms_ff.minute + 1'b1;
               end
            end else begin
               hms_in.second = hms_ff.second + 1'b1;
            end
         end
         OP_TICK_DOWN: begin
            if (hms_ff.second == '0) begin
               hms_in.second = LAST_SEC;
               if (hms_ff.minute == '0) begin
                  hms_in.minute = LAST_MIN;
                  hms_in.hour   = (hms_ff.hour == '0) ? LAST_HOUR : hms_ff.hour - 1'b1;
               end else begin
                  hms_in.minute = hms_ff.minute - 1'b1;
               end
            end else begin
               hms_in.second = hms_ff.second - 1'b1;
            end
         end
         OP_ADD_MIN: begin
            if (hms_ff.minute == LAST_MIN) begin
               hms_in.minute = '0;
               hms_in.hour   = (hms_ff.hour == LAST_HOUR) ? '0 : hms_ff.hour + 1'b1;
            end else begin
               hms_in.minute = hms_ff.minute + 1'b1;
            end
         end
         OP_ADD_HOUR: begin
            hms_in.hour = (hms_ff.hour == LAST_HOUR) ? '0 : hms_ff.hour + 1'b1;
         end
         OP_LOAD: begin
            // hour twelve and anything past it load as zero, as do bad minutes/seconds
            hms_in.hour   = (lh_ff > FIELD_W'(LAST_HOUR)) ? '0 : lh_ff[HOUR_W-1:0];
            hms_in.minute = (lm_ff > LAST_MIN) ? '0 : lm_ff;
            hms_in.second = (ls_ff > LAST_SEC) ? '0 : ls_ff;
         end
         default: begin
            hms_in = hms_ff;   // hold, and the two spare codes
         end
      endcase
   end

   // Readout of the new time
   always_comb begin
      if (hms_in.hour == '0) begin
         hour_tens_in = 1'b1;   // zero hour shows as 12
         hour_ones_in = 4'd2;
      end else if (hms_in.hour >= HOUR_W'(10)) begin
         hour_tens_in = 1'b1;
         hour_ones_in = hms_in.hour - HOUR_W'(10);
      end else begin
         hour_tens_in = 1'b0;
         hour_ones_in = hms_in.hour;
      end
      min_tens_in = tens_digit(hms_in.minute);
      min_ones_in = ones_digit(hms_in.minute);
      sec_tens_in = tens_digit(hms_in.second);
      sec_ones_in = ones_digit(hms_in.second);
      count_in    = COUNT_W'(hms_in.hour) * COUNT_W'(HOUR_SECONDS)
                  + COUNT_W'(hms_in.minute) * COUNT_W'(MINUTE_SECONDS)
                  + COUNT_W'(hms_in.second);
   end

   // Control and time state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hms_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            hms_ff <= hms_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff <= req_op;
         lh_ff <= req_load_hour;
         lm_ff <= req_load_minute;
         ls_ff <= req_load_second;
      end
      if (advance) begin
         hour_tens_ff <= hour_tens_in;
         hour_ones_ff <= hour_ones_in;
         min_tens_ff  <= min_tens_in;
         min_ones_ff  <= min_ones_in;
         sec_tens_ff  <= sec_tens_in;
         sec_ones_ff  <= sec_ones_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_hour_tens     = hour_tens_ff;
   assign rsp_hour_ones     = hour_ones_ff;
   assign rsp_minute_tens   = min_tens_ff;
   assign rsp_minute_ones   = min_ones_ff;
   assign rsp_second_tens   = sec_tens_ff;
   assign rsp_second_ones   = sec_ones_ff;
   assign rsp_elapsed_count = count_ff;

   // Split time never leaves its range
   a_hms_range: assert property (@(posedge clock) disable iff (reset)
      (hms_ff.hour <= LAST_HOUR) && (hms_ff.minute <= LAST_MIN)
      && (hms_ff.second <= LAST_SEC))
      else $error("time state out of range");

   // Reported count stays below one twelve-hour turn
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elapsed_count < COUNT_W'(TURN_SECONDS)))
      else $error("elapsed count out of range");

   // A hold leaves the time unchanged
   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      (advance && (op_ff == OP_HOLD)) |=> (hms_ff == $past(hms_ff)))
      else $error("hold changed the time");

   // Input stalls only when the input register is full and cannot drain
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("req stall without a blocked result");

endmodule
